FILE: rtl/core/stick_axis_conditioner_defines.svh
// assertion macros shared by the stick axis conditioner rtl
`ifndef STICK_AXIS_CONDITIONER_DEFINES_SVH
`define STICK_AXIS_CONDITIONER_DEFINES_SVH

// expression holds at every clock edge outside reset
`define SAC_ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error(msg);

// expression holds in the same cycle as the condition
`define SAC_ASSERT_IMPLY(label, clk, rstn, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error(msg);

`endif

FILE: rtl/core/sac_pkg.sv
// types and constants of the stick axis conditioner
package sac_pkg;

    // field widths
    localparam int ADC_W      = 12;
    localparam int OUT_W      = 11;
    localparam int BAND_W     = 10;
    localparam int TRIM_W     = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_ADDR_W = 4;

    // divider widths: quotient never exceeds the output span
    localparam int QUO_W = 11;
    localparam int DIV_W = 12;
    localparam int NUM_W = DIV_W + QUO_W;

    // output scale
    localparam logic [OUT_W-1:0] OUT_MIN = 11'd191;
    localparam logic [OUT_W-1:0] OUT_MID = 11'd992;
    localparam logic [OUT_W-1:0] OUT_MAX = 11'd1792;
    localparam logic [OUT_W-1:0] OUT_MIRROR = OUT_MIN + OUT_MAX;
    localparam logic [ADC_W-1:0] ADC_FULL = 12'd4095;

    // register reset values
    localparam logic [ADC_W-1:0] CAL_LOW_RST    = 12'd0;
    localparam logic [ADC_W-1:0] CAL_CENTER_RST = 12'd2048;
    localparam logic [ADC_W-1:0] CAL_HIGH_RST   = 12'd4095;
    localparam logic [OUT_W-1:0] WIN_LOW_RST    = 11'd191;
    localparam logic [OUT_W-1:0] WIN_HIGH_RST   = 11'd1792;

    // register map
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CAL_LOW       = 4'd0,
        REG_CAL_CENTER    = 4'd1,
        REG_CAL_HIGH      = 4'd2,
        REG_DEAD_BAND     = 4'd3,
        REG_MIRROR_ENABLE = 4'd4,
        REG_TRIM_OFFSET   = 4'd5,
        REG_WINDOW_LOW    = 4'd6,
        REG_WINDOW_HIGH   = 4'd7
    } cfg_addr_t;

    typedef struct packed {
        logic [ADC_W-1:0]         cal_low;
        logic [ADC_W-1:0]         cal_center;
        logic [ADC_W-1:0]         cal_high;
        logic [BAND_W-1:0]        dead_band;
        logic                     mirror_enable;
        logic signed [TRIM_W-1:0] trim_offset;
        logic [OUT_W-1:0]         window_low;
        logic [OUT_W-1:0]         window_high;
    } cfg_t;

    // beat handed along the divider chain
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DIV_W-1:0] div;
        logic [QUO_W-1:0] quot;
        logic [OUT_W-1:0] base;
    } div_beat_t;

endpackage

FILE: rtl/core/stick_axis_conditioner.sv
// stick axis conditioner top level: register file, front end, divider chain, back end
// a sample passes front end stages a and b, the divider cells, back end stages c and d
// throughput: one sample per clock without backpressure; 11 cells, one quotient bit each
// every stage holds its beat under backpressure and takes a new one as soon as it empties
// reset (aresetn low, synchronous) empties all stages and loads the register defaults
`include "stick_axis_conditioner_defines.svh"

module stick_axis_conditioner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_addr,
    input  logic [11:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [11:0] s_adc_sample,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [10:0] m_channel_value
);
    import sac_pkg::*;

    localparam int PIPE_DEPTH = QUO_W + 4;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

    cfg_t             cfg_reg;
    logic [QUO_W:0]   chain_valid;
    logic [QUO_W:0]   chain_ready;
    div_beat_t        chain_beat [QUO_W+1];
    logic [CNT_W-1:0] flight_reg;
    logic [CNT_W-1:0] flight_next;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cal_low       <= CAL_LOW_RST;
            cfg_reg.cal_center    <= CAL_CENTER_RST;
            cfg_reg.cal_high      <= CAL_HIGH_RST;
            cfg_reg.dead_band     <= '0;
            cfg_reg.mirror_enable <= 1'b0;
            cfg_reg.trim_offset   <= '0;
            cfg_reg.window_low    <= WIN_LOW_RST;
            cfg_reg.window_high   <= WIN_HIGH_RST;
        end else if (cfg_we) begin
            case (cfg_addr_t'(cfg_addr))
                REG_CAL_LOW:       cfg_reg.cal_low       <= cfg_wdata;
                REG_CAL_CENTER:    cfg_reg.cal_center    <= cfg_wdata;
                REG_CAL_HIGH:      cfg_reg.cal_high      <= cfg_wdata;
                REG_DEAD_BAND:     cfg_reg.dead_band     <= cfg_wdata[BAND_W-1:0];
                REG_MIRROR_ENABLE: cfg_reg.mirror_enable <= cfg_wdata[0];
                REG_TRIM_OFFSET:   cfg_reg.trim_offset   <= $signed(cfg_wdata);
                REG_WINDOW_LOW:    cfg_reg.window_low    <= cfg_wdata[OUT_W-1:0];
                REG_WINDOW_HIGH:   cfg_reg.window_high   <= cfg_wdata[OUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // segment selection and numerator
    sac_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_sample (s_adc_sample),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_beat  (chain_beat[0])
    );

    // divider chain, most significant quotient bit first
    for (genvar i = 0; i < QUO_W; i++) begin : g_cell
        sac_div_cell #(
            .BIT (QUO_W - 1 - i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_beat   (chain_beat[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_beat  (chain_beat[i+1])
        );
    end

    // deadzone, mirror, trim, window and output register
    sac_post u_post (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .in_valid        (chain_valid[QUO_W]),
        .in_ready        (chain_ready[QUO_W]),
        .in_beat         (chain_beat[QUO_W]),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_channel_value (m_channel_value)
    );

    // beats in flight, for the checks below
    assign flight_next = flight_reg + CNT_W'(s_valid && s_ready) - CNT_W'(m_valid && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flight_reg <= '0;
        end else begin
            flight_reg <= flight_next;
        end
    end

    `SAC_ASSERT_IMPLY(a_out_range, aclk, aresetn, m_valid, (m_channel_value >= OUT_MIN) && (m_channel_value <= OUT_MAX), "value out of range")
    `SAC_ASSERT_IMPLY(a_div_rem, aclk, aresetn, chain_valid[QUO_W], chain_beat[QUO_W].rem < NUM_W'(chain_beat[QUO_W].div), "remainder too large")
    `SAC_ASSERT_ALWAYS(a_flight_max, aclk, aresetn, flight_reg <= CNT_W'(PIPE_DEPTH), "too many beats in flight")
    `SAC_ASSERT_IMPLY(a_flight_out, aclk, aresetn, m_valid, flight_reg != '0, "result without a sample")

endmodule

FILE: rtl/core/sac_front.sv
// segment selection and numerator product ahead of the divider chain
module sac_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  sac_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [11:0]       in_sample,
    output logic              out_valid,
    input  logic              out_ready,
    output sac_pkg::div_beat_t out_beat
);
    import sac_pkg::*;

    logic             cal_bad;
    logic [ADC_W-1:0] seg_lo;
    logic [ADC_W-1:0] seg_hi;
    logic [OUT_W-1:0] seg_out_lo;
    logic [OUT_W-1:0] seg_out_hi;

    logic             a_valid_reg;
    logic             a_valid_next;
    logic             a_ready;
    logic [ADC_W-1:0] a_offs_reg;
    logic [ADC_W-1:0] a_offs_next;
    logic [DIV_W-1:0] a_span_reg;
    logic [DIV_W-1:0] a_span_next;
    logic [OUT_W-1:0] a_spo_reg;
    logic [OUT_W-1:0] a_spo_next;
    logic [OUT_W-1:0] a_base_reg;
    logic [OUT_W-1:0] a_base_next;

    logic             b_valid_reg;
    logic             b_valid_next;
    logic             b_ready;
    div_beat_t        b_beat_reg;
    div_beat_t        b_beat_next;
    logic [NUM_W-1:0] b_prod;

    // segment choice from the calibration points
    always_comb begin
        cal_bad = (cfg.cal_center <= cfg.cal_low) || (cfg.cal_high <= cfg.cal_center);
        if (cal_bad) begin
            seg_lo     = '0;
            seg_hi     = ADC_FULL;
            seg_out_lo = OUT_MIN;
            seg_out_hi = OUT_MAX;
        end else if (in_sample <= cfg.cal_center) begin
            seg_lo     = cfg.cal_low;
            seg_hi     = cfg.cal_center;
            seg_out_lo = OUT_MIN;
            seg_out_hi = OUT_MID;
        end else begin
            seg_lo     = cfg.cal_center;
            seg_hi     = cfg.cal_high;
            seg_out_lo = OUT_MID;
            seg_out_hi = OUT_MAX;
        end
    end

    // end points and empty span give a fixed value through a zero numerator
    always_comb begin
        a_offs_next = '0;
        a_span_next = DIV_W'(1);
        a_spo_next  = '0;
        a_base_next = seg_out_lo;
        if (seg_hi <= seg_lo) begin
            a_base_next = seg_out_lo;
        end else if (in_sample <= seg_lo) begin
            a_base_next = seg_out_lo;
        end else if (in_sample >= seg_hi) begin
            a_base_next = seg_out_hi;
        end else begin
            a_offs_next = in_sample - seg_lo;
            a_span_next = seg_hi - seg_lo;
            a_spo_next  = seg_out_hi - seg_out_lo;
        end
    end

    // numerator with half the divisor for rounding
    assign b_prod = NUM_W'(a_offs_reg) * NUM_W'(a_spo_reg);

    always_comb begin
        b_beat_next.rem  = b_prod + NUM_W'(a_span_reg >> 1);
        b_beat_next.div  = a_span_reg;
        b_beat_next.quot = '0;
        b_beat_next.base = a_base_reg;
    end

    // stage handshake
    assign b_ready      = !b_valid_reg || out_ready;
    assign a_ready      = !a_valid_reg || b_ready;
    assign in_ready     = a_ready;
    assign a_valid_next = a_ready ? in_valid : a_valid_reg;
    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && a_ready) begin
            a_offs_reg <= a_offs_next;
            a_span_reg <= a_span_next;
            a_spo_reg  <= a_spo_next;
            a_base_reg <= a_base_next;
        end
        if (a_valid_reg && b_ready) begin
            b_beat_reg <= b_beat_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_beat  = b_beat_reg;

endmodule

FILE: rtl/core/sac_div_cell.sv
// one restoring division cell, settles one quotient bit per beat
module sac_div_cell #(
    parameter int BIT = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  sac_pkg::div_beat_t in_beat,
    output logic               out_valid,
    input  logic               out_ready,
    output sac_pkg::div_beat_t out_beat
);
    import sac_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    div_beat_t        beat_reg;
    div_beat_t        beat_next;
    logic [NUM_W-1:0] div_shift;
    logic             take;

    // trial subtract of the shifted divisor
    assign div_shift = NUM_W'(in_beat.div) << BIT;
    assign take      = in_beat.rem >= div_shift;

    always_comb begin
        beat_next      = in_beat;
        beat_next.rem  = take ? (in_beat.rem - div_shift) : in_beat.rem;
        beat_next.quot = {in_beat.quot[QUO_W-2:0], take};
    end

    // stage handshake
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

FILE: rtl/core/sac_post.sv
// deadzone, mirror, trim and cutoff window after the divider
module sac_post (
    input  logic               aclk,
    input  logic               aresetn,
    input  sac_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  sac_pkg::div_beat_t in_beat,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [10:0]        m_channel_value
);
    import sac_pkg::*;

    logic                   c_valid_reg;
    logic                   c_valid_next;
    logic                   c_ready;
    logic [OUT_W-1:0]       c_val_reg;
    logic [OUT_W-1:0]       c_val_next;
    logic [OUT_W:0]         c_sum;
    logic [OUT_W-1:0]       c_clamped;
    logic [OUT_W-1:0]       c_delta;
    logic [OUT_W-1:0]       c_snapped;

    logic                   d_valid_reg;
    logic                   d_valid_next;
    logic                   d_ready;
    logic [OUT_W-1:0]       d_val_reg;
    logic [OUT_W-1:0]       d_val_next;
    logic signed [OUT_W+1:0] d_sum;
    logic [OUT_W-1:0]       d_trimmed;
    logic [OUT_W-1:0]       win_lo;
    logic [OUT_W-1:0]       win_hi;
    logic [OUT_W-1:0]       lim_lo;
    logic [OUT_W-1:0]       lim_hi;

    // segment base plus quotient, clamped to the output range
    always_comb begin
        c_sum = {1'b0, in_beat.base} + {1'b0, in_beat.quot};
        if (c_sum < {1'b0, OUT_MIN}) begin
            c_clamped = OUT_MIN;
        end else if (c_sum > {1'b0, OUT_MAX}) begin
            c_clamped = OUT_MAX;
        end else begin
            c_clamped = c_sum[OUT_W-1:0];
        end
    end

    // deadzone snap and mirror
    always_comb begin
        c_delta   = (c_clamped > OUT_MID) ? (c_clamped - OUT_MID) : (OUT_MID - c_clamped);
        c_snapped = (c_delta <= {1'b0, cfg.dead_band}) ? OUT_MID : c_clamped;
        c_val_next = cfg.mirror_enable ? (OUT_MIRROR - c_snapped) : c_snapped;
    end

    // trim with saturation
    always_comb begin
        d_sum = $signed({2'b00, c_val_reg})
              + $signed({cfg.trim_offset[TRIM_W-1], cfg.trim_offset});
        if (d_sum < $signed({2'b00, OUT_MIN})) begin
            d_trimmed = OUT_MIN;
        end else if (d_sum > $signed({2'b00, OUT_MAX})) begin
            d_trimmed = OUT_MAX;
        end else begin
            d_trimmed = d_sum[OUT_W-1:0];
        end
    end

    // cutoff window, sanitised to the output range
    always_comb begin
        win_lo = (cfg.window_low < OUT_MIN) ? OUT_MIN : cfg.window_low;
        win_hi = (cfg.window_high > OUT_MAX) ? OUT_MAX : cfg.window_high;
        if (win_hi < win_lo) begin
            lim_lo = OUT_MIN;
            lim_hi = OUT_MAX;
        end else begin
            lim_lo = win_lo;
            lim_hi = win_hi;
        end
        if (d_trimmed < lim_lo) begin
            d_val_next = lim_lo;
        end else if (d_trimmed > lim_hi) begin
            d_val_next = lim_hi;
        end else begin
            d_val_next = d_trimmed;
        end
    end

    // stage handshake, last stage is the output register
    assign d_ready      = !d_valid_reg || m_ready;
    assign c_ready      = !c_valid_reg || d_ready;
    assign in_ready     = c_ready;
    assign c_valid_next = c_ready ? in_valid : c_valid_reg;
    assign d_valid_next = d_ready ? c_valid_reg : d_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            c_valid_reg <= c_valid_next;
            d_valid_reg <= d_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && c_ready) begin
            c_val_reg <= c_val_next;
        end
        if (c_valid_reg && d_ready) begin
            d_val_reg <= d_val_next;
        end
    end

    assign m_valid         = d_valid_reg;
    assign m_channel_value = d_val_reg;

endmodule
